// ----- hw/rtl/sps_pkg.sv -----
package sps_pkg;

    localparam int CODE_W = 32;

    typedef struct packed {
        logic [7:0] sps_byte;
        logic       last_byte;
    } sps_in_t;

    typedef struct packed {
        logic [7:0]  profile;
        logic [7:0]  level;
        logic [4:0]  set_id;
        logic [1:0]  chroma_format;
        logic [16:0] max_frame_number;
        logic [1:0]  order_count_type;
        logic [16:0] max_order_count;
        logic [4:0]  ref_frames;
        logic [15:0] width_pixels;
        logic [15:0] height_pixels;
        logic [4:0]  frame_flags;
        logic [1:0]  status;
    } sps_out_t;

    typedef struct packed {
        logic              done;
        logic              too_long;
        logic [CODE_W-1:0] value;
    } sps_gol_res_t;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TRUNCATED = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG  = 2'd2;
    localparam logic [1:0] STAT_RANGE     = 2'd3;

    localparam logic [7:0] PROF_HIGH     = 8'd100;
    localparam logic [7:0] PROF_HIGH10   = 8'd110;
    localparam logic [7:0] PROF_HIGH422  = 8'd122;
    localparam logic [7:0] PROF_HIGH444  = 8'd144;

    localparam logic [5:0] STEP_PROFILE    = 6'd0;
    localparam logic [5:0] STEP_CONSTRAINT = 6'd1;
    localparam logic [5:0] STEP_LEVEL      = 6'd2;
    localparam logic [5:0] STEP_SET_ID     = 6'd3;
    localparam logic [5:0] STEP_CHROMA     = 6'd4;
    localparam logic [5:0] STEP_RESIDUAL   = 6'd5;
    localparam logic [5:0] STEP_DEPTH_L    = 6'd6;
    localparam logic [5:0] STEP_DEPTH_C    = 6'd7;
    localparam logic [5:0] STEP_BYPASS     = 6'd8;
    localparam logic [5:0] STEP_SCALING    = 6'd9;
    localparam logic [5:0] STEP_SCAL_LIST  = 6'd10;
    localparam logic [5:0] STEP_LOG2_FN    = 6'd11;
    localparam logic [5:0] STEP_POC_TYPE   = 6'd12;
    localparam logic [5:0] STEP_LOG2_POC   = 6'd13;
    localparam logic [5:0] STEP_DELTA_FLAG = 6'd14;
    localparam logic [5:0] STEP_OFF_NREF   = 6'd15;
    localparam logic [5:0] STEP_OFF_TB     = 6'd16;
    localparam logic [5:0] STEP_NUM_CYCLE  = 6'd17;
    localparam logic [5:0] STEP_OFF_LOOP   = 6'd18;
    localparam logic [5:0] STEP_REFS       = 6'd19;
    localparam logic [5:0] STEP_GAPS       = 6'd20;
    localparam logic [5:0] STEP_WIDTH      = 6'd21;
    localparam logic [5:0] STEP_HEIGHT     = 6'd22;
    localparam logic [5:0] STEP_FRAME_ONLY = 6'd23;
    localparam logic [5:0] STEP_ADAPTIVE   = 6'd24;
    localparam logic [5:0] STEP_DIRECT     = 6'd25;
    localparam logic [5:0] STEP_CROP       = 6'd26;
    localparam logic [5:0] STEP_CROP_L     = 6'd27;
    localparam logic [5:0] STEP_CROP_R     = 6'd28;
    localparam logic [5:0] STEP_CROP_T     = 6'd29;
    localparam logic [5:0] STEP_CROP_B     = 6'd30;
    localparam logic [5:0] STEP_VUI        = 6'd31;
    localparam logic [5:0] STEP_DONE       = 6'd32;

    function automatic logic is_golomb(input logic [5:0] s);
        logic r;
        case (s)
            STEP_SET_ID, STEP_CHROMA, STEP_DEPTH_L, STEP_DEPTH_C, STEP_LOG2_FN,
            STEP_POC_TYPE, STEP_LOG2_POC, STEP_OFF_NREF, STEP_OFF_TB,
            STEP_NUM_CYCLE, STEP_OFF_LOOP, STEP_REFS, STEP_WIDTH, STEP_HEIGHT,
            STEP_CROP_L, STEP_CROP_R, STEP_CROP_T, STEP_CROP_B: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Saturating accumulate of picture units; anything above 4095 sticks at 4096.
    function automatic logic [12:0] sat_add(input logic [12:0] a, input logic [CODE_W-1:0] v);
        logic [13:0] s;
        logic [12:0] r;
        s = {1'b0, a} + {1'b0, v[12:0]};
        if ((v > CODE_W'(4095)) || (s > 14'd4095)) begin
            r = 13'd4096;
        end else begin
            r = s[12:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] to_pixels(input logic [12:0] u);
        return u[12] ? 16'hFFFF : {u[11:0], 4'b0000};
    endfunction

endpackage

// ----- hw/rtl/h264_sps_header_parser.sv -----
// Channel | Ports                    | Carries
// input   | s_valid s_ready s_data   | one payload byte and its last marker
// result  | m_valid m_ready m_data   | summary of the parameter set
// A header byte (profile, constraint, level) is taken whole and skips the bit walk.
// Every later byte is accepted, walked bit by bit (Exp-Golomb fields through the
// shared Exp-Golomb unit) and then closed; the walk stops early once the set is
// parsed or an error is seen.
// Reset clears the parse state and drops m_valid. A new byte is taken only when
// the result register is free or being read; a stalled result holds its value.
module h264_sps_header_parser import sps_pkg::*; #(
    parameter int MAX_PREFIX_ZEROS = 31
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sps_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sps_out_t m_data
);

    localparam logic CTL_IDLE = 1'b0;
    localparam logic CTL_BITS = 1'b1;

    logic        ctl_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  err_reg, err_next;
    logic [7:0]  loop_reg, loop_next;
    logic [7:0]  prof_reg, level_reg;
    logic [4:0]  id_reg, id_next;
    logic [1:0]  chroma_reg, chroma_next;
    logic [3:0]  lfn_reg, lfn_next;
    logic [1:0]  poct_reg, poct_next;
    logic [3:0]  lpoc_reg, lpoc_next;
    logic [4:0]  refs_reg, refs_next;
    logic [4:0]  flags_reg, flags_next;
    logic [12:0] wacc_reg, wacc_next;
    logic [12:0] hacc_reg, hacc_next;
    logic        m_valid_reg;
    sps_out_t    m_data_reg, result;

    logic         accept, done_now, consume, cur_bit, isg, elem;
    logic [31:0]  v;
    logic [7:0]   loop_inc, loop_dec;
    logic [1:0]   status;
    sps_gol_res_t gol;

    assign s_ready  = (ctl_reg == CTL_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign done_now = (err_reg != STAT_OK) || (step_reg == STEP_DONE) || cnt_reg[3];
    assign consume  = (ctl_reg == CTL_BITS) && !done_now;
    assign cur_bit  = byte_reg[3'd7 - cnt_reg[2:0]];
    assign isg      = is_golomb(step_reg);

    sps_golomb #(.MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS)) u_golomb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (consume && isg),
        .clr     ((ctl_reg == CTL_BITS) && done_now && last_reg),
        .bit_in  (cur_bit),
        .res     (gol)
    );

    always_comb begin
        step_next   = step_reg;
        err_next    = err_reg;
        loop_next   = loop_reg;
        id_next     = id_reg;
        chroma_next = chroma_reg;
        lfn_next    = lfn_reg;
        poct_next   = poct_reg;
        lpoc_next   = lpoc_reg;
        refs_next   = refs_reg;
        flags_next  = flags_reg;
        wacc_next   = wacc_reg;
        hacc_next   = hacc_reg;
        loop_inc    = loop_reg + 8'd1;
        loop_dec    = loop_reg - 8'd1;
        elem        = isg ? gol.done : 1'b1;
        v           = isg ? gol.value : {31'd0, cur_bit};
        if (consume && isg && gol.too_long) begin
            err_next = STAT_TOO_LONG;
        end else if (consume && elem) begin
            case (step_reg)
                STEP_SET_ID: begin
                    if (v > 32'd31) begin
                        err_next = STAT_RANGE;
                    end else begin
                        id_next = v[4:0];
                        step_next = (prof_reg inside {PROF_HIGH, PROF_HIGH10, PROF_HIGH422,
                                     PROF_HIGH444}) ? STEP_CHROMA : STEP_LOG2_FN;
                    end
                end
                STEP_CHROMA: begin
                    if (v > 32'd3) begin
                        err_next = STAT_RANGE;
                    end else begin
                        chroma_next = v[1:0];
                        step_next = (v[1:0] == 2'd3) ? STEP_RESIDUAL : STEP_DEPTH_L;
                    end
                end
                STEP_RESIDUAL: step_next = STEP_DEPTH_L;
                STEP_DEPTH_L, STEP_DEPTH_C: begin
                    if (v > 32'd6) begin
                        err_next = STAT_RANGE;
                    end else begin
                        step_next = step_reg + 6'd1;
                    end
                end
                STEP_BYPASS: step_next = STEP_SCALING;
                STEP_SCALING: begin
                    loop_next = '0;
                    step_next = v[0] ? STEP_SCAL_LIST : STEP_LOG2_FN;
                end
                STEP_SCAL_LIST: begin
                    loop_next = loop_inc;
                    if (loop_inc >= 8'd8) begin
                        step_next = STEP_LOG2_FN;
                    end
                end
                STEP_LOG2_FN: begin
                    if (v > 32'd12) begin
                        err_next = STAT_RANGE;
                    end else begin
                        lfn_next = v[3:0];
                        step_next = STEP_POC_TYPE;
                    end
                end
                STEP_POC_TYPE: begin
                    if (v > 32'd2) begin
                        err_next = STAT_RANGE;
                    end else begin
                        poct_next = v[1:0];
                        step_next = (v[1:0] == 2'd0) ? STEP_LOG2_POC :
                                    (v[1:0] == 2'd1) ? STEP_DELTA_FLAG : STEP_REFS;
                    end
                end
                STEP_LOG2_POC: begin
                    if (v > 32'd12) begin
                        err_next = STAT_RANGE;
                    end else begin
                        lpoc_next = v[3:0];
                        step_next = STEP_REFS;
                    end
                end
                STEP_DELTA_FLAG: step_next = STEP_OFF_NREF;
                STEP_OFF_NREF:   step_next = STEP_OFF_TB;
                STEP_OFF_TB:     step_next = STEP_NUM_CYCLE;
                STEP_NUM_CYCLE: begin
                    if (v > 32'd255) begin
                        err_next = STAT_RANGE;
                    end else begin
                        loop_next = v[7:0];
                        step_next = (v[7:0] != 8'd0) ? STEP_OFF_LOOP : STEP_REFS;
                    end
                end
                STEP_OFF_LOOP: begin
                    loop_next = loop_dec;
                    if (loop_dec == 8'd0) begin
                        step_next = STEP_REFS;
                    end
                end
                STEP_REFS: begin
                    if (v > 32'd16) begin
                        err_next = STAT_RANGE;
                    end else begin
                        refs_next = v[4:0];
                        step_next = STEP_GAPS;
                    end
                end
                STEP_GAPS: step_next = STEP_WIDTH;
                STEP_WIDTH: begin
                    wacc_next = sat_add(13'd1, v);
                    step_next = STEP_HEIGHT;
                end
                STEP_HEIGHT: begin
                    hacc_next = sat_add(13'd1, v);
                    step_next = STEP_FRAME_ONLY;
                end
                STEP_FRAME_ONLY: begin
                    flags_next[0] = flags_reg[0] | v[0];
                    step_next = v[0] ? STEP_DIRECT : STEP_ADAPTIVE;
                end
                STEP_ADAPTIVE: begin
                    flags_next[1] = flags_reg[1] | v[0];
                    step_next = STEP_DIRECT;
                end
                STEP_DIRECT: begin
                    flags_next[2] = flags_reg[2] | v[0];
                    step_next = STEP_CROP;
                end
                STEP_CROP: begin
                    flags_next[3] = flags_reg[3] | v[0];
                    step_next = v[0] ? STEP_CROP_L : STEP_VUI;
                end
                STEP_CROP_L, STEP_CROP_R: begin
                    wacc_next = sat_add(wacc_reg, v);
                    step_next = step_reg + 6'd1;
                end
                STEP_CROP_T, STEP_CROP_B: begin
                    hacc_next = sat_add(hacc_reg, v);
                    step_next = step_reg + 6'd1;
                end
                STEP_VUI: begin
                    flags_next[4] = flags_reg[4] | v[0];
                    step_next = STEP_DONE;
                end
                default: step_next = STEP_DONE;
            endcase
        end
    end

    always_comb begin
        status = (err_reg != STAT_OK) ? err_reg :
                 (step_reg != STEP_DONE) ? STAT_TRUNCATED : STAT_OK;
        result = '0;
        result.status = status;
        if (status == STAT_OK) begin
            result.profile          = prof_reg;
            result.level            = level_reg;
            result.set_id           = id_reg;
            result.chroma_format    = chroma_reg;
            result.max_frame_number = 17'd16 << lfn_reg;
            result.order_count_type = poct_reg;
            result.max_order_count  = (poct_reg == 2'd0) ? (17'd16 << lpoc_reg) : 17'd0;
            result.ref_frames       = refs_reg;
            result.width_pixels     = to_pixels(wacc_reg);
            result.height_pixels    = to_pixels(hacc_reg);
            result.frame_flags      = flags_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg     <= CTL_IDLE;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            step_reg    <= STEP_PROFILE;
            err_reg     <= STAT_OK;
            loop_reg    <= '0;
            prof_reg    <= '0;
            level_reg   <= '0;
            id_reg      <= '0;
            chroma_reg  <= '0;
            lfn_reg     <= '0;
            poct_reg    <= '0;
            lpoc_reg    <= '0;
            refs_reg    <= '0;
            flags_reg   <= '0;
            wacc_reg    <= '0;
            hacc_reg    <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (ctl_reg)
                CTL_IDLE: begin
                    if (accept) begin
                        ctl_reg  <= CTL_BITS;
                        byte_reg <= s_data.sps_byte;
                        last_reg <= s_data.last_byte;
                        // Header bytes are taken whole; the bit walk is skipped.
                        if ((err_reg == STAT_OK) && (step_reg < STEP_SET_ID)) begin
                            cnt_reg  <= 4'd8;
                            step_reg <= step_reg + 6'd1;
                            if (step_reg == STEP_PROFILE) begin
                                prof_reg <= s_data.sps_byte;
                            end
                            if (step_reg == STEP_LEVEL) begin
                                level_reg <= s_data.sps_byte;
                            end
                        end else begin
                            cnt_reg  <= '0;
                        end
                    end
                end
                CTL_BITS: begin
                    if (done_now) begin
                        ctl_reg <= CTL_IDLE;
                        if (last_reg) begin
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= result;
                            step_reg    <= STEP_PROFILE;
                            err_reg     <= STAT_OK;
                            loop_reg    <= '0;
                            prof_reg    <= '0;
                            level_reg   <= '0;
                            id_reg      <= '0;
                            chroma_reg  <= '0;
                            lfn_reg     <= '0;
                            poct_reg    <= '0;
                            lpoc_reg    <= '0;
                            refs_reg    <= '0;
                            flags_reg   <= '0;
                            wacc_reg    <= '0;
                            hacc_reg    <= '0;
                        end
                    end else begin
                        cnt_reg    <= cnt_reg + 4'd1;
                        step_reg   <= step_next;
                        err_reg    <= err_next;
                        loop_reg   <= loop_next;
                        id_reg     <= id_next;
                        chroma_reg <= chroma_next;
                        lfn_reg    <= lfn_next;
                        poct_reg   <= poct_next;
                        lpoc_reg   <= lpoc_next;
                        refs_reg   <= refs_next;
                        flags_reg  <= flags_next;
                        wacc_reg   <= wacc_next;
                        hacc_reg   <= hacc_next;
                    end
                end
                default: ctl_reg <= CTL_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/sps_golomb.sv -----
module sps_golomb import sps_pkg::*; #(
    parameter int MAX_PREFIX_ZEROS = 31
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         clr,
    input  logic         bit_in,
    output sps_gol_res_t res
);

    logic [5:0]        zero_run_reg, zero_run_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [CODE_W-1:0] code_shift;
    logic [5:0]        zr_dec;

    always_comb begin
        zero_run_next = zero_run_reg;
        code_next     = code_reg;
        res           = '0;
        code_shift    = {code_reg[CODE_W-2:0], bit_in};
        zr_dec        = zero_run_reg - 6'd1;
        if (code_reg == '0) begin
            if (!bit_in) begin
                if (zero_run_reg >= 6'(MAX_PREFIX_ZEROS)) begin
                    res.too_long = en;
                end else begin
                    zero_run_next = zero_run_reg + 6'd1;
                end
            end else if (zero_run_reg == 6'd0) begin
                res.done = en;
            end else begin
                code_next = CODE_W'(1);
            end
        end else begin
            zero_run_next = zr_dec;
            if (zr_dec == 6'd0) begin
                res.done  = en;
                res.value = code_shift - CODE_W'(1);
                code_next = '0;
            end else begin
                code_next = code_shift;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            zero_run_reg <= '0;
            code_reg     <= '0;
        end else if (en) begin
            zero_run_reg <= zero_run_next;
            code_reg     <= code_next;
        end
    end

endmodule
